>>> sv/elop_pkg.sv
package elop_pkg;

	localparam int DEFAULT_COORD_BITS = 9;
	localparam int PT_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CMD_DEPTH = 4;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 2 * PT_W;

	localparam logic [1:0] QUAD_LAST = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X    = 3'd0,
		CFG_CENTER_Y    = 3'd1,
		CFG_MAJOR_END_X = 3'd2,
		CFG_MAJOR_END_Y = 3'd3,
		CFG_MINOR_END_X = 3'd4,
		CFG_MINOR_END_Y = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		CMD_ADVANCE = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		RGN_IDLE,
		RGN_ONE,
		RGN_TWO,
		RGN_CENTER
	} region_t;

	typedef enum logic [2:0] {
		STP_READY,
		STP_SQ,
		STP_PROD,
		STP_INIT,
		STP_RUN
	} stp_state_t;

endpackage

>>> sv/elop_front.sv
module elop_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [elop_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] restart, rest zero
	output logic                               push_valid,
	input  logic                               push_ready,
	output elop_pkg::cmd_t                     push_cmd
);
	import elop_pkg::*;

	logic hold_q;
	cmd_t cmd_q;
	logic take;

	assign s_tready   = !hold_q || push_ready;
	assign take       = s_tvalid && s_tready;
	assign push_valid = hold_q;
	assign push_cmd   = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (take) begin
			hold_q <= 1'b1;
		end else if (push_ready) begin
			hold_q <= 1'b0;
		end
	end

	// classify the word: restart or plain advance
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= s_tdata[0] ? CMD_RESTART : CMD_ADVANCE;
		end
	end

endmodule

>>> sv/elop_cmd_fifo.sv
module elop_cmd_fifo #(
	parameter int DEPTH = elop_pkg::CMD_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  elop_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output elop_pkg::cmd_t pop_cmd
);
	import elop_pkg::*;

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push, do_pop;

	function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
		return (p == PTRW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = (count_q != CNTW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> sv/elop_stepper.sv
module elop_stepper #(
	parameter int COORD_BITS = elop_pkg::DEFAULT_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	input  logic [COORD_BITS-1:0] major_end_x,
	input  logic [COORD_BITS-1:0] major_end_y,
	input  logic [COORD_BITS-1:0] minor_end_x,
	input  logic [COORD_BITS-1:0] minor_end_y,
	input  logic                  cmd_valid,
	input  elop_pkg::cmd_t        cmd,
	output logic                  cmd_pop,
	output logic                  pt_valid,
	input  logic                  pt_ready,
	output logic [COORD_BITS:0]   pt_x,
	output logic [COORD_BITS:0]   pt_y,
	output logic                  pt_last
);
	import elop_pkg::*;

	localparam int AW   = COORD_BITS + 1;
	localparam int SQW  = 2 * AW;
	localparam int PW   = 3 * AW + 1;
	localparam int ACCW = 3 * AW + 5;

	stp_state_t state_q, state_d;
	region_t    region_q, region_d;

	logic [AW-1:0]  a_q, b_q, a_d, b_d;
	logic [SQW-1:0] a_sq_q, b_sq_q;
	logic [PW-1:0]  prod_a_q, prod_b_q;    // 2*b^2*a and 2*a^2*b
	logic [AW-1:0]  cur_x_q, cur_y_q, cur_x_d, cur_y_d;
	logic signed [ACCW-1:0] dx_q, dy_q, err_q, stopx_q, stopy_q, dy2_init_q;
	logic signed [ACCW-1:0] dx_d, dy_d, err_d, stopx_d, stopy_d;
	logic signed [ACCW-1:0] tas, tbs, e1;
	logic [ACCW:0]  test;
	logic           last_d;

	logic pt_valid_q, pt_last_q;
	logic [AW-1:0] pt_x_q, pt_y_q;

	logic slot_free, load_axes, load_sq, load_prod, load_init, do_step;

	function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] p,
	                                                  input logic [COORD_BITS-1:0] q);
		return (p > q) ? p - q : q - p;
	endfunction

	assign a_d = AW'(absdiff(center_x, major_end_x)) + AW'(absdiff(center_y, major_end_y));
	assign b_d = AW'(absdiff(center_x, minor_end_x)) + AW'(absdiff(center_y, minor_end_y));

	assign slot_free = !pt_valid_q || pt_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			STP_READY: begin
				if (cmd_valid && cmd == CMD_RESTART) begin
					state_d = STP_SQ;
				end
			end
			STP_SQ:   state_d = STP_PROD;
			STP_PROD: state_d = STP_INIT;
			STP_INIT: state_d = STP_RUN;
			STP_RUN: begin
				if (slot_free) begin
					state_d = STP_READY;
				end
			end
			default: state_d = STP_READY;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_pop   = 1'b0;
		load_axes = 1'b0;
		load_sq   = 1'b0;
		load_prod = 1'b0;
		load_init = 1'b0;
		do_step   = 1'b0;
		case (state_q)
			STP_READY: begin
				if (cmd_valid) begin
					if (cmd == CMD_RESTART) begin
						cmd_pop   = 1'b1;
						load_axes = 1'b1;
					end else if (region_q == RGN_IDLE) begin
						cmd_pop = 1'b1;     // drop: no outline active
					end else if (slot_free) begin
						cmd_pop = 1'b1;
						do_step = 1'b1;
					end
				end
			end
			STP_SQ:   load_sq   = 1'b1;
			STP_PROD: load_prod = 1'b1;
			STP_INIT: load_init = 1'b1;
			STP_RUN:  do_step   = slot_free;
			default: begin
			end
		endcase
	end

	// one midpoint step of the active region
	always_comb begin
		tas      = ACCW'({a_sq_q, 1'b0});
		tbs      = ACCW'({b_sq_q, 1'b0});
		region_d = region_q;
		cur_x_d  = cur_x_q;
		cur_y_d  = cur_y_q;
		dx_d     = dx_q;
		dy_d     = dy_q;
		err_d    = err_q;
		stopx_d  = stopx_q;
		stopy_d  = stopy_q;
		e1       = '0;
		test     = '0;
		last_d   = 1'b0;
		case (region_q)
			RGN_ONE: begin
				cur_y_d = cur_y_q + 1'b1;
				stopy_d = stopy_q + tas;
				e1      = err_q + dy_q;
				dy_d    = dy_q + tas;
				err_d   = e1;
				test    = {e1, 1'b0} + {dx_q[ACCW-1], dx_q};
				if (!test[ACCW] && test != '0) begin
					cur_x_d = cur_x_q - 1'b1;
					stopx_d = stopx_q - tbs;
					err_d   = e1 + dx_q;
					dx_d    = dx_q + tbs;
				end
				// slope reached -1, or no horizontal axis: switch to region two
				if (stopx_d < stopy_d || a_sq_q == '0) begin
					region_d = RGN_TWO;
					cur_x_d  = '0;
					cur_y_d  = b_q;
					dx_d     = ACCW'(b_sq_q);
					dy_d     = dy2_init_q;
					err_d    = '0;
					stopx_d  = '0;
					stopy_d  = ACCW'(prod_b_q);
				end
			end
			RGN_TWO: begin
				cur_x_d = cur_x_q + 1'b1;
				stopx_d = stopx_q + tbs;
				e1      = err_q + dx_q;
				dx_d    = dx_q + tbs;
				err_d   = e1;
				test    = {e1, 1'b0} + {dy_q[ACCW-1], dy_q};
				if (!test[ACCW] && test != '0) begin
					cur_y_d = cur_y_q - 1'b1;
					stopy_d = stopy_q - tas;
					err_d   = e1 + dy_q;
					dy_d    = dy_q + tas;
				end
				if (stopx_d > stopy_d || b_sq_q == '0) begin
					region_d = RGN_IDLE;
					last_d   = 1'b1;
				end
			end
			RGN_CENTER: begin
				region_d = RGN_IDLE;
				last_d   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= STP_READY;
			region_q   <= RGN_IDLE;
			pt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_init) begin
				region_q <= (a_q == '0 && b_q == '0) ? RGN_CENTER : RGN_ONE;
			end else if (do_step) begin
				region_q <= region_d;
			end
			if (do_step) begin
				pt_valid_q <= 1'b1;
			end else if (pt_ready) begin
				pt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_axes) begin
			a_q <= a_d;
			b_q <= b_d;
		end
		if (load_sq) begin
			a_sq_q <= SQW'(a_q) * SQW'(a_q);
			b_sq_q <= SQW'(b_q) * SQW'(b_q);
		end
		if (load_prod) begin
			prod_a_q <= PW'({b_sq_q, 1'b0}) * PW'(a_q);
			prod_b_q <= PW'({a_sq_q, 1'b0}) * PW'(b_q);
		end
		if (load_init) begin
			cur_x_q    <= a_q;
			cur_y_q    <= '0;
			dx_q       <= ACCW'(b_sq_q) - ACCW'(prod_a_q);
			dy_q       <= ACCW'(a_sq_q);
			err_q      <= '0;
			stopx_q    <= ACCW'(prod_a_q);
			stopy_q    <= '0;
			dy2_init_q <= ACCW'(a_sq_q) - ACCW'(prod_b_q);
		end else if (do_step) begin
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
			dx_q    <= dx_d;
			dy_q    <= dy_d;
			err_q   <= err_d;
			stopx_q <= stopx_d;
			stopy_q <= stopy_d;
		end
		if (do_step) begin
			pt_x_q    <= cur_x_q;
			pt_y_q    <= cur_y_q;
			pt_last_q <= last_d;
		end
	end

	assign pt_valid = pt_valid_q;
	assign pt_x     = pt_x_q;
	assign pt_y     = pt_y_q;
	assign pt_last  = pt_last_q;

`ifndef SYNTHESIS
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from an empty queue");
	a_center_zero_axes: assert property (@(posedge clk) disable iff (!arst_n)
		region_q == RGN_CENTER |-> a_q == '0 && b_q == '0)
		else $error("single-point outline with nonzero axes");
	a_init_starts_outline: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == STP_INIT |=> region_q != RGN_IDLE)
		else $error("setup finished without an active outline");
`endif

endmodule

>>> sv/elop_mirror.sv
module elop_mirror #(
	parameter int COORD_BITS = elop_pkg::DEFAULT_COORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [COORD_BITS-1:0]              center_x,
	input  logic [COORD_BITS-1:0]              center_y,
	input  logic                               pt_valid,
	output logic                               pt_ready,
	input  logic [COORD_BITS:0]                pt_x,
	input  logic [COORD_BITS:0]                pt_y,
	input  logic                               pt_last,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [elop_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast
);
	import elop_pkg::*;

	localparam int AW = COORD_BITS + 1;
	localparam int XW = AW + PT_W;

	logic [AW-1:0]   px_q, py_q;
	logic            last_q, busy_q;
	logic [1:0]      quad_q;
	logic            m_valid_q, m_last_q;
	logic [PT_W-1:0] m_x_q, m_y_q;
	logic            out_ok, adv, take, neg_x, neg_y;
	logic [XW-1:0]   sum_x, sum_y;

	assign out_ok   = !m_valid_q || m_tready;
	assign adv      = busy_q && out_ok;
	assign pt_ready = !busy_q || (adv && quad_q == QUAD_LAST);
	assign take     = pt_valid && pt_ready;

	// quadrant order: (x,y) (-x,y) (-x,-y) (x,-y)
	assign neg_x = quad_q[0] ^ quad_q[1];
	assign neg_y = quad_q[1];
	assign sum_x = neg_x ? XW'(center_x) - XW'(px_q) : XW'(center_x) + XW'(px_q);
	assign sum_y = neg_y ? XW'(center_y) - XW'(py_q) : XW'(center_y) + XW'(py_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			quad_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				quad_q <= quad_q + 1'b1;
				if (quad_q == QUAD_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (take) begin
				busy_q <= 1'b1;
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_q   <= pt_x;
			py_q   <= pt_y;
			last_q <= pt_last;
		end
		if (adv) begin
			m_x_q    <= sum_x[PT_W-1:0];
			m_y_q    <= sum_y[PT_W-1:0];
			m_last_q <= last_q && (quad_q == QUAD_LAST);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_y_q, m_x_q};
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_idle_quad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> quad_q == '0)
		else $error("quadrant counter not parked while idle");
	a_take_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy_q && quad_q == '0)
		else $error("accepted point not loaded for mirroring");
`endif

endmodule

>>> sv/ellipse_outline_point_generator_top.sv
// Ellipse outline generator. Write the center and the two axis end points on the cfg port
// while the block is idle; each semi-axis is the Manhattan distance from the center to its
// end point. Every input word (s_tdata[0] = restart) yields one quadrant point, sent as four
// mirrored output words (x,y) (-x,y) (-x,-y) (x,-y) offset by the center, with tlast on the
// fourth word of the final point. A restart word runs the setup steps (axes, squares,
// cross products, initial terms) before its first point. The mirror stage sends one
// output word per cycle unless m_tready stalls it. Advance words with no active outline
// give no output. Up to four commands queue between the input stage and the stepper, so
// input and output stall independently. No clearing pass after reset.
module ellipse_outline_point_generator_top #(
	parameter int COORD_BITS = elop_pkg::DEFAULT_COORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [elop_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [COORD_BITS-1:0]              cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [elop_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] restart
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [elop_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [11:0] point_x, [23:12] point_y
	output logic                               m_tlast    // last_point
);
	import elop_pkg::*;

	logic [COORD_BITS-1:0] center_x_q, center_y_q;
	logic [COORD_BITS-1:0] major_end_x_q, major_end_y_q;
	logic [COORD_BITS-1:0] minor_end_x_q, minor_end_y_q;

	logic push_valid, push_ready, cmd_valid, cmd_pop;
	cmd_t push_cmd, cmd;
	logic pt_valid, pt_ready, pt_last;
	logic [COORD_BITS:0] pt_x, pt_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			major_end_x_q <= '0;
			major_end_y_q <= '0;
			minor_end_x_q <= '0;
			minor_end_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CENTER_X:    center_x_q    <= cfg_wdata;
				CFG_CENTER_Y:    center_y_q    <= cfg_wdata;
				CFG_MAJOR_END_X: major_end_x_q <= cfg_wdata;
				CFG_MAJOR_END_Y: major_end_y_q <= cfg_wdata;
				CFG_MINOR_END_X: minor_end_x_q <= cfg_wdata;
				CFG_MINOR_END_Y: minor_end_y_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	elop_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	elop_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_pop),
		.pop_cmd    (cmd)
	);

	elop_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.major_end_x (major_end_x_q),
		.major_end_y (major_end_y_q),
		.minor_end_x (minor_end_x_q),
		.minor_end_y (minor_end_y_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.pt_valid    (pt_valid),
		.pt_ready    (pt_ready),
		.pt_x        (pt_x),
		.pt_y        (pt_y),
		.pt_last     (pt_last)
	);

	elop_mirror #(
		.COORD_BITS (COORD_BITS)
	) u_mirror (
		.clk      (clk),
		.arst_n   (arst_n),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.pt_valid (pt_valid),
		.pt_ready (pt_ready),
		.pt_x     (pt_x),
		.pt_y     (pt_y),
		.pt_last  (pt_last),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
